// ===== src/sbv_pkg.sv =====
// ----------------------------------------------------------------------------
// sbv_pkg
// Shared types and constants for the stack bytecode validator: opcodes,
// operation kinds, error codes, the decoder state and the result record.
// ----------------------------------------------------------------------------
package sbv_pkg;

  // Limits of the checked machine.
  localparam int STORE_SLOTS    = 64;
  localparam int STACK_LIMIT    = 255;
  localparam int MAX_CODE_BYTES = 65536;

  // Opcode byte values.
  localparam logic [7:0] OPC_STOP  = 8'h00;
  localparam logic [7:0] OPC_LOAD  = 8'h01;
  localparam logic [7:0] OPC_STORE = 8'h02;
  localparam logic [7:0] OPC_POP   = 8'h03;
  localparam logic [7:0] OPC_ADD   = 8'h04;
  localparam logic [7:0] OPC_SUB   = 8'h05;
  localparam logic [7:0] OPC_DUP   = 8'h06;

  typedef enum logic [2:0] {
    KIND_STOP  = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_STORE = 3'd2,
    KIND_POP   = 3'd3,
    KIND_ADD   = 3'd4,
    KIND_SUB   = 3'd5,
    KIND_DUP   = 3'd6
  } op_kind_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_UNKNOWN   = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_MISSING   = 3'd3,
    ERR_STORE_IDX = 3'd4,
    ERR_NO_STOP   = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_t;

  // Which opcode, if any, is waiting for its argument byte.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_LOAD  = 2'd1,
    PEND_STORE = 2'd2
  } pend_t;

  typedef struct packed {
    logic        halted;
    pend_t       pend;
    logic [15:0] pend_off;
    logic [7:0]  depth;
    logic [7:0]  max_depth;
    logic [15:0] pos;
  } state_t;

  typedef struct packed {
    err_t        err;
    logic [7:0]  peak;
    logic [15:0] offset;
    logic [7:0]  depth_in;
    logic [7:0]  index;
    op_kind_t    kind;
  } result_t;

endpackage

// ===== src/stack_bytecode_validator.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_validator
// Checks a stack-machine bytecode program arriving one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one bytecode byte per beat in s_tdata, s_tuser set on
//   the first byte of a program, s_tlast set on its last byte.
//   Output stream (m_*): one beat per completed op or per error, carrying the
//   op kind, its argument, the depth before it, its opcode offset, the peak
//   depth so far and an error code. After an error or a STOP the block drops
//   bytes silently until the next first byte.
//   Path: a byte that completes a result waits in the input register, is
//   decoded in a single pass and its result is captured in the result register.
//   Throughput: one byte per cycle while no stall holds the input register.
//   Stalls: while the result register is full and m_tready is low, a byte
//   that would produce a result waits in the input register and s_tready
//   falls; bytes producing no result still pass.
//   Reset: rst clears the decoder state as for a fresh program and empties
//   both registers.
// ----------------------------------------------------------------------------
module stack_bytecode_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tuser,   // [0] first_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [2:0] op_kind, [10:3] op_index,
                                 // [18:11] depth_before, [34:19] op_offset,
                                 // [42:35] peak_depth, [45:43] error_code
);
  import sbv_pkg::*;

  logic       in_valid;
  logic [7:0] in_code;
  logic       in_first;
  logic       in_last;
  state_t     st;
  state_t     st_next;
  result_t    res;
  logic       res_valid;
  result_t    out_res;
  logic       out_valid;
  logic       out_free;
  logic       in_consume;

  // Single decode pass over the registered byte.
  sbv_decode u_decode (
    .code      (in_code),
    .first     (in_first),
    .last      (in_last),
    .st        (st),
    .nx        (st_next),
    .res       (res),
    .res_valid (res_valid)
  );

  // Handshake between the input register and the result register.
  assign out_free   = !out_valid || m_tready;
  assign in_consume = in_valid && (!res_valid || out_free);
  assign s_tready   = !in_valid || in_consume;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (in_consume) begin
        st <= st_next;
      end
      if (in_consume && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code  <= s_tdata;
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
    if (in_consume && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  // A halted decoder never waits for an argument.
  a_halt_no_pend: assert property (@(posedge clk) disable iff (rst)
    st.halted |-> st.pend == PEND_NONE)
    else $error("halted decoder with a pending argument");

  // The recorded peak never trails the live depth.
  a_peak_covers_depth: assert property (@(posedge clk) disable iff (rst)
    st.depth <= st.max_depth)
    else $error("stack depth above recorded peak");

  // Every reported op starts from a depth within the peak.
  a_result_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.peak >= out_res.depth_in)
    else $error("result peak below depth before op");

  // An error or a STOP leaves the decoder halted.
  a_halt_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_consume && res_valid && (res.err != ERR_OK || res.kind == KIND_STOP))
      |=> st.halted)
    else $error("decoder not halted after error or STOP");

endmodule

// ===== src/sbv_decode.sv =====
// ----------------------------------------------------------------------------
// sbv_decode
// Single-pass decode of one bytecode byte: works out the next decoder state
// and, for a completed op or an error, the result record.
// ----------------------------------------------------------------------------
module sbv_decode (
  input  logic             [7:0] code,
  input  logic                   first,
  input  logic                   last,
  input  sbv_pkg::state_t        st,
  output sbv_pkg::state_t        nx,
  output sbv_pkg::result_t       res,
  output logic                   res_valid
);
  import sbv_pkg::*;

  state_t     e;
  logic       last_eff;
  logic [7:0] depth_n;
  op_kind_t   kind;
  err_t       err;
  logic       emit;

  always_comb begin
    // A first byte starts from a cleared state.
    e        = first ? '0 : st;
    nx       = e;
    last_eff = last || ({1'b0, e.pos} >= 17'(MAX_CODE_BYTES - 1));
    depth_n  = e.depth;
    kind     = KIND_STOP;
    err      = ERR_OK;
    emit     = 1'b0;
    res      = '0;

    if (!e.halted) begin
      nx.pos       = e.pos + 16'd1;
      emit         = 1'b1;
      res.depth_in = e.depth;
      res.offset   = e.pos;

      case (e.pend)
        PEND_LOAD: begin
          kind       = KIND_LOAD;
          res.index  = code;
          res.offset = e.pend_off;
          if (e.depth >= 8'(STACK_LIMIT)) begin
            err = ERR_OVERFLOW;
          end else begin
            depth_n = e.depth + 8'd1;
          end
        end
        PEND_STORE: begin
          kind       = KIND_STORE;
          res.index  = code;
          res.offset = e.pend_off;
          if ({1'b0, code} >= 9'(STORE_SLOTS)) begin
            err = ERR_STORE_IDX;
          end
        end
        default: begin
          case (code)
            OPC_STOP: begin
              kind = KIND_STOP;
            end
            OPC_LOAD: begin
              kind = KIND_LOAD;
              if (last_eff) begin
                err = ERR_MISSING;
              end else begin
                emit = 1'b0;
              end
            end
            OPC_STORE: begin
              kind = KIND_STORE;
              if (e.depth == 8'd0) begin
                err = ERR_UNDERFLOW;
              end else if (last_eff) begin
                err = ERR_MISSING;
              end else begin
                emit = 1'b0;
              end
            end
            OPC_POP: begin
              kind = KIND_POP;
              if (e.depth == 8'd0) begin
                err = ERR_UNDERFLOW;
              end else begin
                depth_n = e.depth - 8'd1;
              end
            end
            OPC_ADD, OPC_SUB: begin
              kind = (code == OPC_ADD) ? KIND_ADD : KIND_SUB;
              if (e.depth <= 8'd1) begin
                err = ERR_UNDERFLOW;
              end else begin
                depth_n = e.depth - 8'd1;
              end
            end
            OPC_DUP: begin
              kind = KIND_DUP;
              if (e.depth == 8'd0) begin
                err = ERR_UNDERFLOW;
              end else if (e.depth >= 8'(STACK_LIMIT)) begin
                err = ERR_OVERFLOW;
              end else begin
                depth_n = e.depth + 8'd1;
              end
            end
            default: begin
              kind = KIND_STOP;
              err  = ERR_UNKNOWN;
            end
          endcase
        end
      endcase

      if (emit) begin
        // The op is complete: update depth and peak, and after an error or a STOP close the program.
        nx.pend  = PEND_NONE;
        nx.depth = depth_n;
        if (err == ERR_OK && depth_n > e.max_depth) begin
          nx.max_depth = depth_n;
        end
        if (err == ERR_OK && kind != KIND_STOP && last_eff) begin
          err = ERR_NO_STOP;
        end
        if (err != ERR_OK || kind == KIND_STOP) begin
          nx.halted = 1'b1;
        end
      end else begin
        // The opcode waits for its argument byte.
        nx.pend     = (kind == KIND_LOAD) ? PEND_LOAD : PEND_STORE;
        nx.pend_off = e.pos;
      end

      res.kind = kind;
      res.err  = err;
      res.peak = nx.max_depth;
    end

    res_valid = emit;
  end

endmodule
